// ===== rtl/has_pkg.sv =====
// has_pkg: shared types and codes for the heading alignment sequencer
// operation codes, motor command codes, phase state type and the reciprocal constant
// no dependencies
package has_pkg;

    // input operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    // motor command codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_STOP  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // phase codes as seen on the result port
    localparam logic [1:0] PHASE_MEASURE = 2'd0;
    localparam logic [1:0] PHASE_TURN    = 2'd1;
    localparam logic [1:0] PHASE_SETTLE  = 2'd2;

    // heading arithmetic in tenths of a degree
    localparam int HALF_TURN = 1800;
    localparam int FULL_TURN = 3600;

    // 5/6 as a fixed point reciprocal, exact for magnitudes up to half a turn
    localparam int          RECIP_SHIFT = 18;
    localparam logic [17:0] RECIP_5_6   = 18'd218455;

    // register reset values and indexes
    localparam logic [10:0] THRESHOLD_RESET = 11'd25;
    localparam logic [15:0] SETTLE_RESET    = 16'd500;
    localparam logic        REG_THRESHOLD   = 1'b0;
    localparam logic        REG_SETTLE      = 1'b1;

    // sequencer phase, one-hot
    typedef enum logic [2:0] {
        PH_MEASURE = 3'b001,
        PH_TURN    = 3'b010,
        PH_SETTLE  = 3'b100
    } phase_t;

endpackage

// ===== rtl/heading_align_sequencer.sv =====
// heading_align_sequencer: turn-in-place heading alignment sequencer, top level
// holds the target, phase and tick counters and the registered result stage
// depends on has_pkg
//
// usage
//   input channel (in_valid/in_ready) carries one transaction per item: op, heading, target.
//   op tick advances the measure/turn/settle cycle with one compass sample, op set
//   arms a new target heading, op cancel disarms and commands stop.
//   output channel (out_valid/out_ready) returns exactly one transaction per input
//   transaction: direction, success, phase and armed after that item.
//   configuration: cfg_we writes cfg_data into register cfg_index at the clock edge
//   (0 heading threshold, 1 settle wait); write only while no transaction is in flight.
// timing
//   the result register loads at the edge that accepts the item; throughput is one
//   item per cycle while the receiver keeps up, set by the single result register; the state
//   update for an item completes in the same edge, so the next item sees it at once.
// stall and reset
//   while the receiver holds out_ready low and a result is waiting, in_ready drops;
//   a result taken in the same cycle frees the register for the next item.
//   reset clears the target, phase, counters and result valid and loads the register
//   defaults (threshold 25, settle wait 500).
module heading_align_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    // input transactions
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [12:0] heading,
    input  logic [11:0]        target,
    // result transactions
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         direction,
    output logic               success,
    output logic [1:0]         phase,
    output logic               armed
);

    // configuration registers
    logic [10:0] threshold_reg;
    logic [15:0] settle_wait_reg;

    // sequencer state
    logic [11:0]     target_reg,  target_next;
    logic            armed_reg,   armed_next;
    has_pkg::phase_t phase_reg,   phase_next;
    logic [10:0]     turn_reg,    turn_next;
    logic [15:0]     elapsed_reg, elapsed_next;

    // result register
    logic       out_valid_reg;
    logic [1:0] direction_reg, direction_next;
    logic       success_reg,   success_next;
    logic [1:0] phase_out_reg, phase_out_next;
    logic       armed_out_reg;

    logic accept;

    // heading error datapath
    logic signed [13:0] diff_raw;
    logic signed [13:0] diff_wrap;
    logic [10:0]        err_mag;
    logic [28:0]        turn_prod;
    logic [10:0]        turn_calc;
    logic [15:0]        elapsed_inc;
    logic               sample_ok;
    logic               in_threshold;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // wrapped error target - heading, one wrap step keeps it within half a turn
    assign diff_raw = $signed({2'b00, target_reg}) - $signed({2'b00, heading[11:0]});

    always_comb
    begin
        if (diff_raw > 14'(has_pkg::HALF_TURN))
            diff_wrap = diff_raw - 14'(has_pkg::FULL_TURN);
        else if (diff_raw < -14'(has_pkg::HALF_TURN))
            diff_wrap = diff_raw + 14'(has_pkg::FULL_TURN);
        else
            diff_wrap = diff_raw;
    end

    assign err_mag      = diff_wrap[13] ? 11'(-diff_wrap) : diff_wrap[10:0];
    assign in_threshold = err_mag < threshold_reg;

    // turn length 5*|error|/6 through the fixed point reciprocal
    assign turn_prod = {18'd0, err_mag} * {11'd0, has_pkg::RECIP_5_6};
    assign turn_calc = turn_prod[has_pkg::RECIP_SHIFT +: 11];

    // elapsed counter saturates at full scale
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign sample_ok   = !heading[12];

    always_comb
    begin
        target_next    = target_reg;
        armed_next     = armed_reg;
        phase_next     = phase_reg;
        turn_next      = turn_reg;
        elapsed_next   = elapsed_reg;
        direction_next = has_pkg::DIR_NONE;
        success_next   = 1'b0;

        case (op)
            has_pkg::OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (armed_reg)
                begin
                    case (phase_reg)
                        has_pkg::PH_MEASURE:
                        begin
                            if (sample_ok)
                            begin
                                if (in_threshold)
                                begin
                                    // aligned: stop and disarm
                                    direction_next = has_pkg::DIR_STOP;
                                    success_next   = 1'b1;
                                    armed_next     = 1'b0;
                                end
                                else if (!diff_wrap[13] && diff_wrap != 14'sd0)
                                    direction_next = has_pkg::DIR_RIGHT;
                                else
                                    direction_next = has_pkg::DIR_LEFT;
                                turn_next    = turn_calc;
                                elapsed_next = 16'd0;
                                phase_next   = has_pkg::PH_TURN;
                            end
                        end
                        has_pkg::PH_TURN:
                        begin
                            if (elapsed_inc >= {5'd0, turn_reg})
                            begin
                                direction_next = has_pkg::DIR_STOP;
                                elapsed_next   = 16'd0;
                                phase_next     = has_pkg::PH_SETTLE;
                            end
                        end
                        has_pkg::PH_SETTLE:
                        begin
                            if (elapsed_inc >= settle_wait_reg)
                                phase_next = has_pkg::PH_MEASURE;
                        end
                        default:
                        begin
                            phase_next = has_pkg::PH_MEASURE;
                        end
                    endcase
                end
            end
            has_pkg::OP_SET:
            begin
                target_next = target;
                armed_next  = 1'b1;
            end
            has_pkg::OP_CANCEL:
            begin
                direction_next = has_pkg::DIR_STOP;
                armed_next     = 1'b0;
            end
            default:
            begin
                // unknown op leaves everything as it is
                direction_next = has_pkg::DIR_NONE;
            end
        endcase
    end

    // phase after the item, as reported
    always_comb
    begin
        case (phase_next)
            has_pkg::PH_MEASURE: phase_out_next = has_pkg::PHASE_MEASURE;
            has_pkg::PH_TURN:    phase_out_next = has_pkg::PHASE_TURN;
            has_pkg::PH_SETTLE:  phase_out_next = has_pkg::PHASE_SETTLE;
            default:             phase_out_next = has_pkg::PHASE_MEASURE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= has_pkg::THRESHOLD_RESET;
            settle_wait_reg <= has_pkg::SETTLE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == has_pkg::REG_THRESHOLD)
                threshold_reg <= cfg_data[10:0];
            else
                settle_wait_reg <= cfg_data;
        end
    end

    // sequencer state, updated on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= 12'd0;
            armed_reg   <= 1'b0;
            phase_reg   <= has_pkg::PH_MEASURE;
            turn_reg    <= 11'd0;
            elapsed_reg <= 16'd0;
        end
        else if (accept)
        begin
            target_reg  <= target_next;
            armed_reg   <= armed_next;
            phase_reg   <= phase_next;
            turn_reg    <= turn_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            direction_reg <= direction_next;
            success_reg   <= success_next;
            phase_out_reg <= phase_out_next;
            armed_out_reg <= armed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = direction_reg;
    assign success   = success_reg;
    assign phase     = phase_out_reg;
    assign armed     = armed_out_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for heading_align_sequencer, predicts every result
// transaction from its own model of the sequencer and compares field by field
// depends on has_pkg and rtl/heading_align_sequencer.sv
module tb;

    // op code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles with no transaction before the run is declared hung
    localparam int WATCHDOG_LIMIT = 400;
    // ticks parked in a settle wait at the top of the register range
    localparam int LONG_SETTLE_TICKS = 40;

    // one result transaction, in port order
    typedef struct packed {
        logic [1:0] direction;
        logic       success;
        logic [1:0] phase;
        logic       armed;
    } outcome_t;

    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_DRAIN
    } entry_kind_t;

    // one pending stimulus step: an item, a register write or a pause
    typedef struct {
        entry_kind_t kind;
        logic [1:0]  op;
        logic [12:0] heading;
        logic [11:0] target;
        logic        cfg_idx;
        logic [15:0] cfg_val;
        int          idle_pct;
        int          stall_pct;
    } stim_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = has_pkg::OP_TICK;
    logic signed [12:0] heading = '0;
    logic [11:0]        target = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         direction;
    logic               success;
    logic [1:0]         phase;
    logic               armed;

    heading_align_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .heading   (heading),
        .target    (target),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .direction (direction),
        .success   (success),
        .phase     (phase),
        .armed     (armed)
    );

    // predicted sequencer state and registers, reset values
    logic [10:0] reg_threshold = has_pkg::THRESHOLD_RESET;
    logic [15:0] reg_settle    = has_pkg::SETTLE_RESET;
    logic [11:0] trk_target    = '0;
    logic        trk_armed     = 1'b0;
    logic [1:0]  trk_phase     = has_pkg::PHASE_MEASURE;
    logic [10:0] trk_turn_len  = '0;
    logic [15:0] trk_elapsed   = '0;

    stim_entry_t stim_queue[$];
    outcome_t    cmd_queue[$];

    // handshake bookkeeping shared between the edges
    bit in_took      = 1'b0;
    int quiet_cycles = 0;
    int stuck_cycles = 0;
    bit timed_out    = 1'b0;
    int send_gap     = 0;
    int hold_gap     = 0;
    int stall_pct    = 0;
    int gen_idle     = 0;
    int gen_stall    = 0;

    // run statistics
    int fail_count   = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int aligned_cnt  = 0;
    int right_cnt    = 0;
    int left_cnt     = 0;
    int cfg_writes   = 0;
    bit saturated    = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    // next motor command for one accepted item; advances the predicted state
    function automatic outcome_t advance_sequencer(logic [1:0] opc, logic [12:0] hdg,
                                                   logic [11:0] tgt);
        outcome_t res;
        int       err;
        int       mag;
        res.direction = has_pkg::DIR_NONE;
        res.success   = 1'b0;
        case (opc)
            has_pkg::OP_TICK:
            begin
                // elapsed count runs on every tick, armed or not
                if (trk_elapsed != 16'hFFFF)
                    trk_elapsed = trk_elapsed + 16'd1;
                if (trk_elapsed == 16'hFFFF)
                    saturated = 1'b1;
                if (trk_armed) begin
                    case (trk_phase)
                        has_pkg::PHASE_MEASURE:
                        begin
                            // negative sample is invalid: nothing happens
                            if (!hdg[12]) begin
                                err = int'(trk_target) - int'(hdg);
                                // single wrap into about one half turn either way
                                if (err > has_pkg::HALF_TURN)
                                    err = err - has_pkg::FULL_TURN;
                                else if (err < -has_pkg::HALF_TURN)
                                    err = err + has_pkg::FULL_TURN;
                                mag = (err < 0) ? -err : err;
                                if (mag < int'(reg_threshold)) begin
                                    res.direction = has_pkg::DIR_STOP;
                                    res.success   = 1'b1;
                                    trk_armed     = 1'b0;
                                end
                                else if (err > 0)
                                    res.direction = has_pkg::DIR_RIGHT;
                                else
                                    res.direction = has_pkg::DIR_LEFT;
                                trk_turn_len = 11'((mag * 5) / 6);
                                trk_elapsed  = '0;
                                trk_phase    = has_pkg::PHASE_TURN;
                            end
                        end
                        has_pkg::PHASE_TURN:
                        begin
                            if (trk_elapsed >= 16'(trk_turn_len)) begin
                                res.direction = has_pkg::DIR_STOP;
                                trk_elapsed   = '0;
                                trk_phase     = has_pkg::PHASE_SETTLE;
                            end
                        end
                        default:
                        begin
                            if (trk_elapsed >= reg_settle)
                                trk_phase = has_pkg::PHASE_MEASURE;
                        end
                    endcase
                end
            end
            has_pkg::OP_SET:
            begin
                // phase is kept, so a new target resumes where the cycle stood
                trk_target = tgt;
                trk_armed  = 1'b1;
            end
            has_pkg::OP_CANCEL:
            begin
                res.direction = has_pkg::DIR_STOP;
                trk_armed     = 1'b0;
            end
            default: ;
        endcase
        res.phase = trk_phase;
        res.armed = trk_armed;
        return res;
    endfunction

    task automatic check_field(string what, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // sample at the rising edge: config writes, result transactions, then new items
    always @(posedge clk) begin
        outcome_t want;
        outcome_t got;
        if (rst_n) begin
            if (cfg_we) begin
                cfg_writes++;
                if (cfg_index == has_pkg::REG_THRESHOLD)
                    reg_threshold = cfg_data[10:0];
                else
                    reg_settle = cfg_data;
            end
            // compare before queuing this edge's item: its result shows up next cycle
            if (out_valid && out_ready) begin
                got = {direction, success, phase, armed};
                results_seen++;
                if (cmd_queue.size() == 0) begin
                    $display("%0t ns: result transaction, expected none, actual %h",
                             $time, got);
                    fail_count++;
                end
                else begin
                    want = cmd_queue.pop_front();
                    check_field("direction", want.direction, got.direction);
                    check_field("success", 2'(want.success), 2'(got.success));
                    check_field("phase", want.phase, got.phase);
                    check_field("armed", 2'(want.armed), 2'(got.armed));
                end
            end
            in_took = in_valid && in_ready;
            if (in_took) begin
                want = advance_sequencer(op, heading, target);
                cmd_queue.push_back(want);
                items_taken++;
                if (want.success)
                    aligned_cnt++;
                if (want.direction == has_pkg::DIR_RIGHT)
                    right_cnt++;
                if (want.direction == has_pkg::DIR_LEFT)
                    left_cnt++;
            end
            // idle means nothing owed and nothing offered
            if (cmd_queue.size() == 0 && !in_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (in_took || (out_valid && out_ready) || cfg_we)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
    end

    // drive at the falling edge: sender from the stimulus queue, receiver stalls
    always @(negedge clk) begin
        stim_entry_t ent;
        logic        nxt_valid;
        logic        nxt_we;
        logic        nxt_ready;
        nxt_valid = in_valid;
        nxt_we    = 1'b0;
        nxt_ready = out_ready;
        if (rst_n) begin
            // only move on once the current transaction is gone
            if (!in_valid || in_took) begin
                nxt_valid = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (stim_queue.size() > 0) begin
                    ent = stim_queue[0];
                    case (ent.kind)
                        ENT_ITEM:
                        begin
                            if ($urandom_range(0, 99) < ent.idle_pct)
                                send_gap = $urandom_range(0, 6);
                            else begin
                                void'(stim_queue.pop_front());
                                nxt_valid = 1'b1;
                                op        <= ent.op;
                                heading   <= ent.heading;
                                target    <= ent.target;
                                stall_pct = ent.stall_pct;
                            end
                        end
                        ENT_CFG:
                        begin
                            // registers change only with nothing in flight
                            if (quiet_cycles >= 2) begin
                                void'(stim_queue.pop_front());
                                nxt_we    = 1'b1;
                                cfg_index <= ent.cfg_idx;
                                cfg_data  <= ent.cfg_val;
                            end
                        end
                        default:
                        begin
                            if (quiet_cycles >= 2)
                                void'(stim_queue.pop_front());
                        end
                    endcase
                end
            end
            // receiver stalls come in bursts, started at random by the entry's stall percentage
            nxt_ready = 1'b1;
            if (hold_gap > 0) begin
                hold_gap--;
                nxt_ready = 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct) begin
                hold_gap  = $urandom_range(0, 6);
                nxt_ready = 1'b0;
            end
        end
        in_valid  <= nxt_valid;
        cfg_we    <= nxt_we;
        out_ready <= nxt_ready;
    end

    task automatic push_item(logic [1:0] opc, logic [12:0] hdg, logic [11:0] tgt);
        stim_entry_t ent;
        ent.kind      = ENT_ITEM;
        ent.op        = opc;
        ent.heading   = hdg;
        ent.target    = tgt;
        ent.cfg_idx   = 1'b0;
        ent.cfg_val   = '0;
        ent.idle_pct  = gen_idle;
        ent.stall_pct = gen_stall;
        stim_queue.push_back(ent);
    endtask

    task automatic push_cfg(logic idx, logic [15:0] val);
        stim_entry_t ent;
        ent.kind      = ENT_CFG;
        ent.op        = has_pkg::OP_TICK;
        ent.heading   = '0;
        ent.target    = '0;
        ent.cfg_idx   = idx;
        ent.cfg_val   = val;
        ent.idle_pct  = gen_idle;
        ent.stall_pct = gen_stall;
        stim_queue.push_back(ent);
    endtask

    // mostly legal headings, sometimes past the end of the scale
    function automatic logic [11:0] pick_target();
        if ($urandom_range(0, 9) == 0)
            return 12'($urandom_range(3600, 4095));
        return 12'($urandom_range(0, has_pkg::FULL_TURN - 1));
    endfunction

    // samples cluster around the aim so turns stay short and cycles repeat
    function automatic logic [12:0] pick_heading(logic [11:0] aim);
        int sel;
        int ofs;
        int h;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            ofs = $urandom_range(0, 160);
            h   = int'(aim) + ofs - 80;
            if (h < 0)
                h = h + has_pkg::FULL_TURN;
            else if (h > 4095)
                h = h - has_pkg::FULL_TURN;
            return 13'(h);
        end
        else if (sel < 80)
            return 13'($urandom_range(0, has_pkg::FULL_TURN - 1));
        else if (sel < 88)
            return 13'($urandom_range(3600, 4095));
        // sign bit set: invalid sample
        return 13'h1000 | 13'($urandom_range(0, 4095));
    endfunction

    initial begin
        logic [11:0] aim;
        int          thr;
        int          settle;
        int          count;
        int          len;
        int          sel;

        // directed part under the reset register values
        push_item(has_pkg::OP_TICK, 13'd0, 12'd0);         // tick with no target
        push_item(OP_UNUSED, 13'h1FFF, 12'hFFF);           // unknown op is ignored
        push_item(has_pkg::OP_CANCEL, 13'd0, 12'd0);       // cancel while disarmed
        push_item(has_pkg::OP_SET, 13'd0, 12'd0);
        push_item(has_pkg::OP_TICK, 13'h1FFF, 12'd0);      // invalid sample, -1
        push_item(has_pkg::OP_TICK, 13'h1000, 12'd0);      // invalid sample, most negative
        push_item(has_pkg::OP_TICK, 13'd3590, 12'd0);      // wraps to +10: aligned, stop
        push_item(has_pkg::OP_SET, 13'd0, 12'hFFF);        // out-of-range target, phase kept
        repeat (8)
            push_item(has_pkg::OP_TICK, pick_heading(12'd0), 12'd0); // turn of 8 ticks ends
        push_item(has_pkg::OP_TICK, 13'd4095, 12'd0);      // settling, largest positive sample
        push_item(has_pkg::OP_CANCEL, 13'h0AAA, 12'h555);

        // settle wait at full scale: the cycle stays parked once it reaches settle
        push_cfg(has_pkg::REG_SETTLE, 16'hFFFF);
        aim = pick_target();
        push_item(has_pkg::OP_SET, 13'($urandom), aim);
        repeat (LONG_SETTLE_TICKS)
            push_item(has_pkg::OP_TICK, pick_heading(aim), 12'($urandom));

        // random part: well-formed set/tick runs with noise, over several settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 3)
                0: begin gen_idle = 0;  gen_stall = 0;  end
                1: begin gen_idle = 15; gen_stall = 15; end
                default: begin gen_idle = 35; gen_stall = 35; end
            endcase
            // the closing phase runs without idling on either side
            if (ph == 7) begin
                gen_idle  = 0;
                gen_stall = 0;
            end
            case (ph)
                0: begin thr = 0;    settle = 0; end
                1: begin thr = 1800; settle = $urandom_range(1, 4); end
                2: begin thr = 2047; settle = 0; end
                3: begin thr = $urandom_range(5, 90); settle = 1; end
                default: begin thr = $urandom_range(5, 90); settle = $urandom_range(0, 15); end
            endcase
            // upper data bits above the threshold width are noise
            push_cfg(has_pkg::REG_THRESHOLD, {5'($urandom), 11'(thr)});
            push_cfg(has_pkg::REG_SETTLE, 16'(settle));
            count = 0;
            while (count < 175) begin
                aim = pick_target();
                push_item(has_pkg::OP_SET, 13'($urandom), aim);
                count++;
                len = $urandom_range(8, 40);
                repeat (len) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 88)
                        push_item(has_pkg::OP_TICK, pick_heading(aim), 12'($urandom));
                    else if (sel < 92) begin
                        aim = pick_target();
                        push_item(has_pkg::OP_SET, 13'($urandom), aim);
                    end
                    else if (sel < 96)
                        push_item(has_pkg::OP_CANCEL, 13'($urandom), 12'($urandom));
                    else
                        push_item(OP_UNUSED, 13'($urandom), 12'($urandom));
                    count++;
                end
                // sender holds off until every result is back
                if (ph == 4 && count > 80 && count < 120)
                    push_cfg(has_pkg::REG_SETTLE, 16'(settle));
            end
            if (ph == 5) begin
                stim_queue.push_back('{ENT_DRAIN, has_pkg::OP_TICK, 13'd0, 12'd0, 1'b0,
                                       16'd0, gen_idle, gen_stall});
            end
        end

        // reset held low from the start, then released on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!timed_out && (stim_queue.size() > 0 || in_valid || cmd_queue.size() > 0))
            @(negedge clk);

        if (timed_out) begin
            $display("%0t ns: no transaction for %0d cycles, %0d results still owed",
                     $time, WATCHDOG_LIMIT, cmd_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
        else begin
            // the result is registered, so a short tail catches any stray result
            repeat (8) @(negedge clk);
            if (cmd_queue.size() != 0) begin
                $display("%0t ns: %0d expected results never arrived", $time, cmd_queue.size());
                fail_count++;
            end
            $display("run covered %0d items and %0d results: %0d aligned, %0d right, %0d left",
                     items_taken, results_seen, aligned_cnt, right_cnt, left_cnt);
            $display("%0d register writes, elapsed counter saturated: %0d, failures: %0d",
                     cfg_writes, saturated, fail_count);
            if (fail_count == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
